// File: hdl/plt_pkg.sv
package plt_pkg;

	// Partner link codes.
	localparam logic [7:0] POLL_BYTE = 8'hE0;
	localparam logic [7:0] BUSY_BYTE = 8'hE1;

	// Source of an input transfer.
	localparam logic KIND_PARTNER = 1'b0;
	localparam logic KIND_HOST    = 1'b1;

	// Kind of a result transfer.
	localparam logic RK_TX     = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_BAD_LENGTH = 2'd1,
		ST_BUSY       = 2'd2
	} load_status_t;

endpackage

// File: hdl/plt_mem.sv
module plt_mem #(
	parameter int DEPTH = 40,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	// Single write port; contents are undefined until written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/polled_link_tx_buffer_top.sv
// An echo or load status is offered in the cycle after its input transfer; the first byte of
// a released message follows once its memory read has returned into the output register.
// One input transfer a cycle while no message is sent and out_ready does not hold the output;
// a released message goes out byte by byte, each read then sent; input resumes after the last.
// Reset (arst_n, asynchronous, active low) clears the flags, length, load position and output
// register; the message memory is not cleared and needs no clearing pass.
module polled_link_tx_buffer_top #(
	parameter int BUFFER_DEPTH = 40
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] byte_value,
	input  logic       message_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic [1:0] load_status,
	output logic       partner_busy
);

	import plt_pkg::*;

	// Address width of the message memory, and width of a count that can
	// reach BUFFER_DEPTH itself (the load position saturates there).
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int LW = $clog2(BUFFER_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WAIT
	} state_t;

	state_t        state_q;
	logic          busy_q;
	logic          pending_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] pos_q;
	logic [AW-1:0] rd_idx_q;

	logic          out_valid_q;
	logic          result_kind_q;
	logic [7:0]    tx_byte_q;
	logic          tx_last_q;
	load_status_t  load_status_q;
	logic          partner_busy_q;

	logic          in_fire;
	logic          host_store;
	logic [LW-1:0] pos_upd;
	logic          start_send;
	logic          next_byte;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          rd_last;
	load_status_t  end_status;

	// New input is taken only between answers, and only when the output
	// register is empty or its result is leaving in this cycle.
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;

	// A host byte is stored only while nothing is pending and the buffer
	// still has room; beyond that the position saturates.
	assign host_store = in_fire && (kind == KIND_HOST) && !pending_q &&
	                    (pos_q < LW'(BUFFER_DEPTH));
	assign pos_upd    = host_store ? (pos_q + LW'(1)) : pos_q;

	// Busy or pending wins over length; a full count is a bad length.
	always_comb begin
		if (pending_q || busy_q) begin
			end_status = ST_BUSY;
		end else if (pos_upd >= LW'(BUFFER_DEPTH)) begin
			end_status = ST_BAD_LENGTH;
		end else begin
			end_status = ST_ACCEPTED;
		end
	end

	// A poll with a message pending starts the send at entry zero; each
	// taken byte that is not the last fetches the following entry. Loads
	// and sends never overlap, since loads are only taken in the idle state
	// and sending holds the block out of it.
	assign start_send = in_fire && (kind == KIND_PARTNER) &&
	                    (byte_value == POLL_BYTE) && pending_q;
	assign next_byte  = (state_q == S_WAIT) && out_ready && !tx_last_q;
	assign rd_en      = start_send || next_byte;
	assign rd_addr    = start_send ? '0 : (rd_idx_q + AW'(1));

	// The entry just read is the last one when its index plus one equals the
	// stored length; for a non-empty message the index never exceeds BUFFER_DEPTH - 2 here.
	assign rd_last = ((LW'(rd_idx_q) + LW'(1)) == len_q);

	plt_mem #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (host_store),
		.wr_addr (pos_q[AW-1:0]),
		.wr_data (byte_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			busy_q         <= 1'b0;
			pending_q      <= 1'b0;
			len_q          <= '0;
			pos_q          <= '0;
			rd_idx_q       <= '0;
			out_valid_q    <= 1'b0;
			result_kind_q  <= RK_TX;
			tx_byte_q      <= '0;
			tx_last_q      <= 1'b0;
			load_status_q  <= ST_ACCEPTED;
			partner_busy_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_fire) begin
						if (kind == KIND_PARTNER) begin
							if (byte_value == POLL_BYTE) begin
								busy_q <= 1'b0;
								if (pending_q) begin
									pending_q <= 1'b0;
									rd_idx_q  <= '0;
									state_q   <= S_READ;
								end else begin
									out_valid_q    <= 1'b1;
									result_kind_q  <= RK_TX;
									tx_byte_q      <= POLL_BYTE;
									tx_last_q      <= 1'b1;
									load_status_q  <= ST_ACCEPTED;
									partner_busy_q <= 1'b0;
								end
							end else if (byte_value == BUSY_BYTE) begin
								busy_q         <= 1'b1;
								out_valid_q    <= 1'b1;
								result_kind_q  <= RK_TX;
								tx_byte_q      <= POLL_BYTE;
								tx_last_q      <= 1'b1;
								load_status_q  <= ST_ACCEPTED;
								partner_busy_q <= 1'b1;
							end
						end else begin
							if (message_end) begin
								// The position returns to zero whatever the status.
								pos_q          <= '0;
								out_valid_q    <= 1'b1;
								result_kind_q  <= RK_STATUS;
								tx_byte_q      <= '0;
								tx_last_q      <= 1'b0;
								load_status_q  <= end_status;
								partner_busy_q <= busy_q;
								if (end_status == ST_ACCEPTED) begin
									pending_q <= 1'b1;
									len_q     <= pos_upd;
								end
							end else begin
								pos_q <= pos_upd;
							end
						end
					end
				end
				S_READ: begin
					out_valid_q    <= 1'b1;
					result_kind_q  <= RK_TX;
					tx_byte_q      <= rd_data;
					tx_last_q      <= rd_last;
					load_status_q  <= ST_ACCEPTED;
					partner_busy_q <= busy_q;
					state_q        <= S_WAIT;
				end
				S_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (tx_last_q) begin
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= rd_addr;
							state_q  <= S_READ;
						end
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = result_kind_q;
	assign tx_byte      = tx_byte_q;
	assign tx_last      = tx_last_q;
	assign load_status  = load_status_q;
	assign partner_busy = partner_busy_q;

endmodule
